[src/uhce_pkg.sv]
package uhce_pkg;

  localparam int PacketBytes  = 64;
  localparam int FeatureBytes = 64;

  localparam logic [1:0] CMD_RESET = 2'd0;
  localparam logic [1:0] CMD_EVENT = 2'd1;
  localparam logic [1:0] CMD_OUT   = 2'd2;

  localparam logic [2:0] SRC_DEV  = 3'd0;
  localparam logic [2:0] SRC_CFG  = 3'd1;
  localparam logic [2:0] SRC_REP  = 3'd2;
  localparam logic [2:0] SRC_LANG = 3'd3;
  localparam logic [2:0] SRC_MANU = 3'd4;
  localparam logic [2:0] SRC_PROD = 3'd5;
  localparam logic [2:0] SRC_FEAT = 3'd6;

  typedef enum logic [1:0] {STG_IDLE, STG_IN, STG_OUT} stage_t;
  typedef enum logic [1:0] {CS_IDLE, CS_DECODE, CS_SEND, CS_FLAGS} ctl_state_t;

  typedef struct packed {
    logic       clear_sent_stall;
    logic       clear_setup_end;
    logic       out_serviced;
    logic       in_packet_ready;
    logic       data_end;
    logic       send_stall;
    logic       address_write;
    logic [7:0] new_address;
    logic       configure_endpoint;
  } flags_t;

  typedef struct packed {
    logic       accept;
    logic       step;
    logic       send_done;
  } ctl_cmd_t;

  typedef struct packed {
    logic       has_bytes;
    logic       has_flags;
    logic       last_byte;
  } dp_stat_t;

  function automatic logic [7:0] rom_byte(input logic [2:0] src, input logic [6:0] off);
    logic [7:0] b;
    b = 8'h00;
    unique case (src)
      SRC_DEV: begin
        unique case (off)
          7'd0: b = 8'h12; 7'd1: b = 8'h01; 7'd2: b = 8'h00; 7'd3: b = 8'h02;
          7'd4: b = 8'h00; 7'd5: b = 8'h00; 7'd6: b = 8'h00; 7'd7: b = 8'h40;
          7'd8: b = 8'h54; 7'd9: b = 8'h53; 7'd10: b = 8'h80; 7'd11: b = 8'h43;
          7'd12: b = 8'h00; 7'd13: b = 8'h01; 7'd14: b = 8'h01; 7'd15: b = 8'h02;
          7'd16: b = 8'h00; 7'd17: b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      SRC_CFG: begin
        unique case (off)
          7'd0: b = 8'h09; 7'd1: b = 8'h02; 7'd2: b = 8'h29; 7'd3: b = 8'h00;
          7'd4: b = 8'h01; 7'd5: b = 8'h01; 7'd6: b = 8'h00; 7'd7: b = 8'h80;
          7'd8: b = 8'h32; 7'd9: b = 8'h09; 7'd10: b = 8'h04; 7'd11: b = 8'h00;
          7'd12: b = 8'h00; 7'd13: b = 8'h02; 7'd14: b = 8'h03; 7'd15: b = 8'h00;
          7'd16: b = 8'h00; 7'd17: b = 8'h00; 7'd18: b = 8'h09; 7'd19: b = 8'h21;
          7'd20: b = 8'h01; 7'd21: b = 8'h01; 7'd22: b = 8'h00; 7'd23: b = 8'h01;
          7'd24: b = 8'h22; 7'd25: b = 8'h1b; 7'd26: b = 8'h00; 7'd27: b = 8'h07;
          7'd28: b = 8'h05; 7'd29: b = 8'h81; 7'd30: b = 8'h03; 7'd31: b = 8'h40;
          7'd32: b = 8'h00; 7'd33: b = 8'h01; 7'd34: b = 8'h07; 7'd35: b = 8'h05;
          7'd36: b = 8'h01; 7'd37: b = 8'h03; 7'd38: b = 8'h40; 7'd39: b = 8'h00;
          7'd40: b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      SRC_REP: begin
        unique case (off)
          7'd0: b = 8'h05; 7'd1: b = 8'h0c; 7'd2: b = 8'h09; 7'd3: b = 8'h01;
          7'd4: b = 8'ha1; 7'd5: b = 8'h01; 7'd6: b = 8'h15; 7'd7: b = 8'h00;
          7'd8: b = 8'h25; 7'd9: b = 8'hff; 7'd10: b = 8'h75; 7'd11: b = 8'h08;
          7'd12: b = 8'h95; 7'd13: b = 8'h40; 7'd14: b = 8'h09; 7'd15: b = 8'h01;
          7'd16: b = 8'hb1; 7'd17: b = 8'h02; 7'd18: b = 8'h09; 7'd19: b = 8'h01;
          7'd20: b = 8'h81; 7'd21: b = 8'h02; 7'd22: b = 8'h09; 7'd23: b = 8'h01;
          7'd24: b = 8'h91; 7'd25: b = 8'h02; 7'd26: b = 8'hc0;
          default: b = 8'h00;
        endcase
      end
      SRC_LANG: begin
        unique case (off)
          7'd0: b = 8'h04; 7'd1: b = 8'h03; 7'd2: b = 8'h09; 7'd3: b = 8'h04;
          default: b = 8'h00;
        endcase
      end
      SRC_MANU: begin
        unique case (off)
          7'd0: b = 8'h08; 7'd1: b = 8'h03; 7'd2: b = 8'h53; 7'd4: b = 8'h54;
          7'd6: b = 8'h43;
          default: b = 8'h00;
        endcase
      end
      SRC_PROD: begin
        unique case (off)
          7'd0: b = 8'h1e; 7'd1: b = 8'h03; 7'd2: b = 8'h53; 7'd4: b = 8'h54;
          7'd6: b = 8'h43; 7'd8: b = 8'h38; 7'd10: b = 8'h20; 7'd12: b = 8'h46;
          7'd14: b = 8'h77; 7'd16: b = 8'h4c; 7'd18: b = 8'h69; 7'd20: b = 8'h62;
          7'd22: b = 8'h20; 7'd24: b = 8'h48; 7'd26: b = 8'h49; 7'd28: b = 8'h44;
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[src/usb_hid_control_endpoint_top.sv]
// Channel | Beat fields (tdata / tuser)                                 | Direction
// in_     | tdata: command[1:0], sent_stall, setup_end, out_ready,      | slave
//         |   in_busy, request_type, request_code, request_value,       |
//         |   request_length, out_byte (62 bits, padded to 64);         |
//         |   tlast: packet_end                                          |
// out_    | tdata: data_byte, data_valid, clear_sent_stall,             | master
//         |   clear_setup_end, out_serviced, in_packet_ready, data_end, |
//         |   send_stall, address_write, new_address, configure_endpoint|
//         |   (25 bits, padded to 32); tlast: last                       |
// An item is accepted, then decoded, then sent as up to 64 transmit beats (the last
// carrying the flags), as one flags beat, or with no beat if it raises no flags;
// no new item is accepted before that. After reset the feature store is swept to
// zero; in_tready stays low until the sweep ends. out_tready low holds the current beat.
module usb_hid_control_endpoint_top
  import uhce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // command, sent_stall, setup_end, out_ready, in_busy,
                                  // request_type, request_code, request_value,
                                  // request_length, out_byte, zero pad
  input  logic        in_tlast,   // packet_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // data_byte, data_valid, clear_sent_stall,
                                  // clear_setup_end, out_serviced, in_packet_ready,
                                  // data_end, send_stall, address_write,
                                  // new_address, configure_endpoint, zero pad
  output logic        out_tlast   // last
);

  ctl_cmd_t   cmd;
  dp_stat_t   stat;
  flags_t     flags;
  logic       emit_flags, emit_byte;
  logic       ctl_ready;
  logic [7:0] data_byte;
  logic [62:0] item;

  assign item = {in_tlast, in_tdata[61:0]};

  // Acceptance is held off here during the datapath's clearing sweep.
  logic rdy_gate_r;
  logic [6:0] sweep_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r    <= '0;
      rdy_gate_r <= 1'b0;
    end else if (!rdy_gate_r) begin
      sweep_r    <= sweep_r + 7'd1;
      rdy_gate_r <= (sweep_r == 7'(FeatureBytes));
    end
  end

  uhce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid && rdy_gate_r),
    .in_tready  (ctl_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .emit_flags (emit_flags),
    .emit_byte  (emit_byte)
  );

  assign in_tready = ctl_ready && rdy_gate_r;

  uhce_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (item),
    .emit_flags (emit_flags),
    .emit_byte  (emit_byte),
    .stat       (stat),
    .data_byte  (data_byte),
    .flags      (flags)
  );

  assign out_tdata = {7'd0, flags.configure_endpoint, flags.new_address,
                      flags.address_write, flags.send_stall, flags.data_end,
                      flags.in_packet_ready, flags.out_serviced,
                      flags.clear_setup_end, flags.clear_sent_stall,
                      emit_byte, data_byte};
  assign out_tlast = emit_flags;

endmodule

[src/uhce_ctrl.sv]
module uhce_ctrl
  import uhce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_stat_t   stat,
  output ctl_cmd_t   cmd,
  output logic       emit_flags,
  output logic       emit_byte
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    emit_flags = 1'b0;
    emit_byte  = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = CS_DECODE;
        end
      end
      CS_DECODE: begin
        if (stat.has_bytes) begin
          state_nxt = CS_SEND;
        end else if (stat.has_flags) begin
          state_nxt = CS_FLAGS;
        end else begin
          state_nxt = CS_IDLE;
        end
      end
      CS_SEND: begin
        out_tvalid = 1'b1;
        emit_byte  = 1'b1;
        emit_flags = stat.last_byte;
        if (out_tready) begin
          cmd.step = 1'b1;
          if (stat.last_byte) begin
            cmd.send_done = 1'b1;
            state_nxt     = CS_IDLE;
          end
        end
      end
      CS_FLAGS: begin
        out_tvalid = 1'b1;
        emit_flags = 1'b1;
        if (out_tready) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  a_send_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_DECODE && stat.has_bytes) |=> state_r == CS_SEND)
    else $error("send not entered");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != CS_IDLE) |-> !in_tready)
    else $error("accept while busy");
  a_ret_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_FLAGS && out_tready) |=> state_r == CS_IDLE)
    else $error("flags beat not closed");

endmodule

[src/uhce_dp.sv]
module uhce_dp
  import uhce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_cmd_t    cmd,
  input  logic [62:0] in_item,
  input  logic        emit_flags,
  input  logic        emit_byte,
  output dp_stat_t    stat,
  output logic [7:0]  data_byte,
  output flags_t      flags
);

  localparam int CntW = $clog2(PacketBytes + 1);
  localparam int FeatW = $clog2(FeatureBytes);

  logic [1:0]  i_cmd;
  logic        i_sent_stall, i_setup_end, i_out_ready, i_in_busy;
  logic [7:0]  i_rtype, i_rcode, i_out_byte;
  logic [15:0] i_value, i_length;
  logic        i_packet_end;

  assign i_cmd        = in_item[1:0];
  assign i_sent_stall = in_item[2];
  assign i_setup_end  = in_item[3];
  assign i_out_ready  = in_item[4];
  assign i_in_busy    = in_item[5];
  assign i_rtype      = in_item[13:6];
  assign i_rcode      = in_item[21:14];
  assign i_value      = in_item[37:22];
  assign i_length     = in_item[53:38];
  assign i_out_byte   = in_item[61:54];
  assign i_packet_end = in_item[62];

  stage_t      stage_r, stage_nxt;
  logic [15:0] residue_r, residue_nxt;
  logic [2:0]  src_r, src_nxt;
  logic [6:0]  off_r, off_nxt;
  flags_t      fl_r, fl_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic        hasb_r, hasb_nxt;

  logic [7:0]  feat_mem [FeatureBytes];
  logic [FeatW:0] clr_r;
  logic        clearing;
  logic        feat_we;
  logic [FeatW-1:0] feat_waddr;
  logic [7:0]  feat_wdata;
  logic [7:0]  feat_rd;
  logic [6:0]  rd_off;

  assign clearing = !clr_r[FeatW];

  // The store is swept to zero after reset before the first item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (clearing) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      feat_mem[clr_r[FeatW-1:0]] <= 8'h00;
    end else if (feat_we) begin
      feat_mem[feat_waddr] <= feat_wdata;
    end
  end

  // Read offset for the next beat: advances on a taken beat.
  assign rd_off = (cmd.step) ? off_r + 7'd1 : off_r;

  always_ff @(posedge clk) begin
    feat_rd <= feat_mem[rd_off[FeatW-1:0]];
  end

  logic feat_in_range;
  always_ff @(posedge clk) begin
    feat_in_range <= (rd_off < 7'(FeatureBytes));
  end

  assign data_byte = !emit_byte ? 8'h00 :
                     (src_r == SRC_FEAT) ? (feat_in_range ? feat_rd : 8'h00) :
                     rom_byte(src_r, off_r);
  assign flags     = emit_flags ? fl_r : '0;
  assign stat.has_bytes = hasb_r;
  assign stat.has_flags = |fl_r;
  assign stat.last_byte = (cnt_r == CntW'(1));

  always_comb begin
    logic [1:0]  kind;
    logic [7:0]  vhi, vlo;
    logic [15:0] len;
    logic [1:0]  action;
    logic        do_chunk;
    logic [15:0] res;
    logic [CntW-1:0] c;
    stage_nxt   = stage_r;
    residue_nxt = residue_r;
    src_nxt     = src_r;
    off_nxt     = off_r;
    fl_nxt      = fl_r;
    cnt_nxt     = cnt_r;
    hasb_nxt    = hasb_r;
    feat_we     = 1'b0;
    feat_waddr  = off_r[FeatW-1:0];
    feat_wdata  = i_out_byte;
    kind   = i_rtype[6:5];
    vhi    = i_value[15:8];
    vlo    = i_value[7:0];
    len    = 16'd0;
    action = 2'd0;
    do_chunk = 1'b0;
    res    = 16'd0;
    c      = '0;
    if (cmd.accept) begin
      fl_nxt   = '0;
      hasb_nxt = 1'b0;
      cnt_nxt  = '0;
      unique case (i_cmd)
        CMD_RESET: stage_nxt = STG_IDLE;
        CMD_EVENT: begin
          if (i_sent_stall) begin
            fl_nxt.clear_sent_stall = 1'b1;
            stage_nxt = STG_IDLE;
          end
          if (i_setup_end) begin
            fl_nxt.clear_setup_end = 1'b1;
            stage_nxt = STG_IDLE;
          end
          res = residue_nxt;
          if (stage_nxt == STG_IN) begin
            do_chunk = !i_in_busy;
          end else if (stage_nxt != STG_OUT) begin
            stage_nxt = STG_IDLE;
            if (i_out_ready) begin
              res = i_length;
              fl_nxt.out_serviced = 1'b1;
              if (kind == 2'd0 && i_rcode == 8'd5) begin
                fl_nxt.address_write = 1'b1;
                fl_nxt.new_address   = vlo;
              end else if (kind == 2'd0 && i_rcode == 8'd9) begin
                fl_nxt.configure_endpoint = 1'b1;
              end else if (kind == 2'd0 && i_rcode == 8'd6) begin
                action = 2'd1;
                if (vhi == 8'h01) begin
                  src_nxt = SRC_DEV; len = 16'd18;
                end else if (vhi == 8'h02) begin
                  src_nxt = SRC_CFG; len = 16'd41;
                end else if (vhi == 8'h22) begin
                  src_nxt = SRC_REP; len = 16'd27;
                end else if (vhi == 8'h03 && vlo == 8'd0) begin
                  src_nxt = SRC_LANG; len = 16'd4;
                end else if (vhi == 8'h03 && vlo == 8'd1) begin
                  src_nxt = SRC_MANU; len = 16'd8;
                end else if (vhi == 8'h03 && vlo == 8'd2) begin
                  src_nxt = SRC_PROD; len = 16'd30;
                end else begin
                  action = 2'd3;
                end
                if (action == 2'd1) begin
                  off_nxt = 7'd0;
                  if (len < res) res = len;
                end
              end else if (kind == 2'd1 && (i_rcode == 8'd1 || i_rcode == 8'd9)) begin
                src_nxt = SRC_FEAT;
                off_nxt = 7'd0;
                if (res > 16'(FeatureBytes)) res = 16'(FeatureBytes);
                action = (i_rcode == 8'd1) ? 2'd1 : 2'd2;
                if (action == 2'd2 && res == 16'd0) action = 2'd0;
              end else if (kind == 2'd1 && i_rcode == 8'd10) begin
                action = 2'd0;
              end else begin
                action = 2'd3;
              end
              unique case (action)
                2'd1: begin
                  stage_nxt = STG_IN;
                  do_chunk  = 1'b1;
                end
                2'd2: stage_nxt = STG_OUT;
                2'd3: fl_nxt.send_stall = 1'b1;
                default: fl_nxt.data_end = 1'b1;
              endcase
            end
          end
          residue_nxt = res;
          if (do_chunk) begin
            c = (res > 16'(PacketBytes)) ? CntW'(PacketBytes) : CntW'(res);
            residue_nxt = res - 16'(c);
            cnt_nxt = c;
            hasb_nxt = (c != '0);
            fl_nxt.in_packet_ready = 1'b1;
            if (residue_nxt == 16'd0) begin
              fl_nxt.data_end = 1'b1;
              stage_nxt = STG_IDLE;
            end
          end
        end
        CMD_OUT: begin
          if (stage_r == STG_OUT) begin
            if (residue_r != 16'd0) begin
              feat_we = (off_r < 7'(FeatureBytes));
              off_nxt = off_r + 7'd1;
              residue_nxt = residue_r - 16'd1;
            end
            if (i_packet_end) begin
              fl_nxt.out_serviced = 1'b1;
              if (residue_nxt == 16'd0) begin
                fl_nxt.data_end = 1'b1;
                stage_nxt = STG_IDLE;
              end
            end
          end
        end
        default: ;
      endcase
    end else if (cmd.step) begin
      off_nxt = off_r + 7'd1;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r   <= STG_IDLE;
      residue_r <= '0;
      src_r     <= '0;
      off_r     <= '0;
      fl_r      <= '0;
      cnt_r     <= '0;
      hasb_r    <= 1'b0;
    end else begin
      stage_r   <= stage_nxt;
      residue_r <= residue_nxt;
      src_r     <= src_nxt;
      off_r     <= off_nxt;
      fl_r      <= fl_nxt;
      cnt_r     <= cnt_nxt;
      hasb_r    <= hasb_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(PacketBytes))
    else $error("chunk too long");
  a_step_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> cnt_r != '0)
    else $error("step with no bytes");
  a_stage_code: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == STG_OUT) |-> src_r == SRC_FEAT)
    else $error("data-out not on feature store");

endmodule
